@@ src/acs_pkg.sv @@
// Shared types and constants of the affinity chunk scheduler.
package acs_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_ITER_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_THREAD_COUNT = 2'd1;

  // Fixed field widths on the ports
  localparam int CfgDataW = 16;
  localparam int TcW      = 5;
  localparam int ReqW     = 4;
  localparam int PosW     = 16;

  // Register reset values
  localparam logic [CfgDataW-1:0] ITER_COUNT_RESET   = 16'd1729;
  localparam logic [TcW-1:0]      THREAD_COUNT_RESET = 5'd4;

  // Item function codes
  localparam logic FUNC_BEGIN = 1'b0;

  typedef enum logic [2:0] {
    OC_STARTED  = 3'd0,
    OC_OWN      = 3'd1,
    OC_STOLEN   = 3'd2,
    OC_ALL_DONE = 3'd3,
    OC_BAD_REQ  = 3'd4
  } outcome_e;

  typedef enum logic {
    DIV_SIZE  = 1'b0,
    DIV_CHUNK = 1'b1
  } div_src_e;

  // Controller to datapath
  typedef struct packed {
    logic     cap;
    logic     div_go;
    div_src_e div_src;
    logic     fill;
    logic     rd_own;
    logic     rd_scan;
    logic     chk;
    logic     result;
    outcome_e outcome;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_begin;
    logic bad_req;
    logic best_zero;
    logic scan_last;
    logic fill_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ src/acs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module acs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ src/acs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module acs_div #(
  parameter int NW = 17,
  parameter int DW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quotient_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] dsr_q;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};
  assign diff   = rem_sh - {1'b0, dsr_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ src/acs_ctrl.sv @@
// Sequencing state machine of the affinity chunk scheduler.
module acs_ctrl import acs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SZ_GO,
    S_SZ_WAIT,
    S_FILL,
    S_OWN_RD,
    S_OWN_CHK,
    S_OWN_DEC,
    S_SCAN,
    S_SCAN_END,
    S_SCAN_DEC,
    S_CH_GO,
    S_CH_WAIT,
    S_RESULT
  } state_e;

  state_e   state_q;
  outcome_e oc_q;

  // State and outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oc_q    <= OC_STARTED;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          if (sts_i.is_begin) begin
            oc_q    <= OC_STARTED;
            state_q <= S_SZ_GO;
          end else if (sts_i.bad_req) begin
            oc_q    <= OC_BAD_REQ;
            state_q <= S_RESULT;
          end else begin
            state_q <= S_OWN_RD;
          end
        end
        S_SZ_GO:   state_q <= S_SZ_WAIT;
        S_SZ_WAIT: begin
          if (sts_i.div_done) state_q <= S_FILL;
        end
        S_FILL: begin
          if (sts_i.fill_last) state_q <= S_RESULT;
        end
        S_OWN_RD:  state_q <= S_OWN_CHK;
        S_OWN_CHK: state_q <= S_OWN_DEC;
        S_OWN_DEC: begin
          if (sts_i.best_zero) begin
            state_q <= S_SCAN;
          end else begin
            oc_q    <= OC_OWN;
            state_q <= S_CH_GO;
          end
        end
        S_SCAN: begin
          if (sts_i.scan_last) state_q <= S_SCAN_END;
        end
        S_SCAN_END: state_q <= S_SCAN_DEC;
        S_SCAN_DEC: begin
          if (sts_i.best_zero) begin
            oc_q    <= OC_ALL_DONE;
            state_q <= S_RESULT;
          end else begin
            oc_q    <= OC_STOLEN;
            state_q <= S_CH_GO;
          end
        end
        S_CH_GO:   state_q <= S_CH_WAIT;
        S_CH_WAIT: begin
          if (sts_i.div_done) state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Decode commands from the state
  always_comb begin
    cmd_o         = '0;
    cmd_o.outcome = oc_q;
    cmd_o.div_src = DIV_SIZE;
    case (state_q)
      S_IDLE:     cmd_o.cap = in_valid_i;
      S_SZ_GO:    cmd_o.div_go = 1'b1;
      S_FILL:     cmd_o.fill = 1'b1;
      S_OWN_RD:   cmd_o.rd_own = 1'b1;
      S_OWN_CHK:  cmd_o.chk = 1'b1;
      S_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        cmd_o.chk     = 1'b1;
      end
      S_SCAN_END: cmd_o.chk = 1'b1;
      S_CH_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DIV_CHUNK;
      end
      S_RESULT:   cmd_o.result = sts_i.out_free;
      default:    cmd_o.cap = 1'b0;
    endcase
  end

  // A division is never started while another runs
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_go |=> !cmd_o.div_go)
    else $error("divider restarted back to back");

  // A begin item always reports started
  a_begin_oc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (oc_q == OC_STARTED))
    else $error("begin item carries wrong outcome");

  // An empty own range always leads to a scan
  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OWN_DEC) && sts_i.best_zero |=> (state_q == S_SCAN))
    else $error("scan not entered after empty own range");

endmodule

@@ src/acs_dp.sv @@
// Datapath: configuration, range table, divider and result register.
module acs_dp import acs_pkg::*; #(
  parameter int MAX_THREADS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                func_i,
  input  logic [ReqW-1:0]     req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosW-1:0]     chunk_start_o,
  output logic [PosW-1:0]     chunk_end_o,
  output logic [2:0]          outcome_o,
  input  cmd_t                cmd_i,
  output sts_t                sts_o
);

  localparam int CB = COUNT_BITS;
  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TW = $clog2(MAX_THREADS + 1);

  // Configuration registers
  logic [CB-1:0]  cnt_q;
  logic [TcW-1:0] tc_q;

  // Item and scan state
  logic                   func_q;
  logic [ReqW-1:0]        req_q;
  logic [IW-1:0]          idx_q;
  logic [CB-1:0]          acc_q;
  logic [CB-1:0]          size_q;
  logic [CB-1:0]          best_q;
  logic [IW-1:0]          pick_q;
  logic [CB-1:0]          pick_start_q;
  logic [CB-1:0]          pick_end_q;
  logic                   rd_vld_q;
  logic [IW-1:0]          rd_idx_q;
  logic                   ent_vld_q;
  logic [MAX_THREADS-1:0] valid_q;

  // Result register
  logic            out_valid_q;
  logic [CB-1:0]   out_start_q;
  logic [CB-1:0]   out_end_q;
  outcome_e        out_oc_q;

  logic [TW-1:0]   t_eff;
  logic [CB:0]     part_sum;
  logic [CB-1:0]   part_end;
  logic            fill_live;
  logic [IW-1:0]   raddr;
  logic            re;
  logic            we;
  logic [IW-1:0]   waddr;
  logic [2*CB-1:0] wdata;
  logic [2*CB-1:0] rdata;
  logic [CB-1:0]   ent_start;
  logic [CB-1:0]   ent_end;
  logic [CB-1:0]   ent_left;
  logic [CB:0]     div_num;
  logic [CB:0]     div_q;
  logic            div_done;
  logic            grant;
  logic [CB-1:0]   grant_end;

  // Effective thread count: zero reads as one, saturate at the bound
  always_comb begin
    if (tc_q == '0) begin
      t_eff = TW'(1);
    end else if (32'(tc_q) > 32'(MAX_THREADS)) begin
      t_eff = TW'(MAX_THREADS);
    end else begin
      t_eff = TW'(tc_q);
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CB'(ITER_COUNT_RESET);
      tc_q  <= THREAD_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ITER_COUNT:   cnt_q <= CB'(cfg_data_i);
        REG_THREAD_COUNT: tc_q  <= cfg_data_i[TcW-1:0];
        default:          tc_q  <= tc_q;
      endcase
    end
  end

  // Partition bound of the current worker, clamped to the count
  assign part_sum  = {1'b0, acc_q} + {1'b0, size_q};
  assign part_end  = (part_sum > {1'b0, cnt_q}) ? cnt_q : part_sum[CB-1:0];
  assign fill_live = 32'(idx_q) < 32'(t_eff);

  // Range table read: own entry or scan index
  assign re    = cmd_i.rd_own | cmd_i.rd_scan;
  assign raddr = cmd_i.rd_own ? IW'(req_q) : idx_q;

  // Range table write: partition fill or chunk commit
  assign grant     = (cmd_i.outcome == OC_OWN) || (cmd_i.outcome == OC_STOLEN);
  assign grant_end = pick_start_q + size_q;
  assign we        = cmd_i.fill | (cmd_i.result & grant);
  assign waddr     = cmd_i.fill ? idx_q : pick_q;
  always_comb begin
    if (cmd_i.fill) begin
      wdata = fill_live ? {acc_q, part_end} : '0;
    end else begin
      wdata = {grant_end, pick_end_q};
    end
  end

  acs_ram #(
    .WIDTH(2 * CB),
    .DEPTH(MAX_THREADS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entries never written read as empty
  assign ent_start = ent_vld_q ? rdata[2*CB-1:CB] : '0;
  assign ent_end   = ent_vld_q ? rdata[CB-1:0] : '0;
  assign ent_left  = (ent_end > ent_start) ? (ent_end - ent_start) : '0;

  // Ceiling division by the thread count
  assign div_num = (cmd_i.div_src == DIV_CHUNK)
                 ? ({1'b0, best_q} + (CB+1)'(t_eff) - 1'b1)
                 : ({1'b0, cnt_q} + (CB+1)'(t_eff) - 1'b1);

  acs_div #(
    .NW(CB + 1),
    .DW(TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_num),
    .divisor_i  (t_eff),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      rd_vld_q <= re;
      if (cmd_i.cap) begin
        idx_q <= '0;
      end else if (cmd_i.fill || cmd_i.rd_scan) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.fill) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ent_vld_q <= valid_q[raddr];
    rd_idx_q  <= raddr;
    if (cmd_i.cap) begin
      func_q <= func_i;
      req_q  <= req_i;
      acc_q  <= '0;
      best_q <= '0;
    end
    if (div_done) begin
      size_q <= div_q[CB-1:0];
    end
    if (cmd_i.fill) begin
      acc_q <= part_end;
    end
    // Keep the first worker with the most left (strictly greater wins)
    if (cmd_i.chk && rd_vld_q && (ent_left > best_q)) begin
      best_q       <= ent_left;
      pick_q       <= rd_idx_q;
      pick_start_q <= ent_start;
      pick_end_q   <= ent_end;
    end
    if (cmd_i.result) begin
      out_start_q <= grant ? pick_start_q : '0;
      out_end_q   <= grant ? grant_end : '0;
      out_oc_q    <= cmd_i.outcome;
    end
  end

  // Status
  assign sts_o.is_begin  = (func_q == FUNC_BEGIN);
  assign sts_o.bad_req   = 32'(req_q) >= 32'(t_eff);
  assign sts_o.best_zero = (best_q == '0);
  assign sts_o.scan_last = (32'(idx_q) + 32'd1) == 32'(t_eff);
  assign sts_o.fill_last = 32'(idx_q) == 32'(MAX_THREADS - 1);
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign chunk_start_o = PosW'(out_start_q);
  assign chunk_end_o   = PosW'(out_end_q);
  assign outcome_o     = out_oc_q;

  // A new result never overwrites one still waiting
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // A granted chunk stays inside the picked range and is not empty
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result && grant |-> (grant_end > pick_start_q) && (grant_end <= pick_end_q))
    else $error("granted chunk outside its range");

  // Results without a grant carry zero bounds
  a_zero_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result && !grant |=> (out_start_q == '0) && (out_end_q == '0))
    else $error("non-grant result with bounds");

endmodule

@@ src/affinity_chunk_scheduler_unit.sv @@
// Top level of the affinity chunk scheduler.
// Hands out chunks of a loop's iterations to up to MAX_THREADS workers. A begin
// beat (tuser 0) splits the iteration count into equal local ranges, one per
// worker; a request beat (tuser 1) returns the next chunk of the requester's own
// range, or once that is empty a chunk stolen from the worker with the most
// left. One item is in work at a time. A begin waits on the bit-serial divider
// for the slice size and then writes every entry of the range table. A request
// waits on the divider for its chunk size, and when its own range is empty it
// first scans all T worker ranges, one table read per cycle. A bad requester
// goes straight to its result. An item holds in its result state while the
// output register is still full. The result sits in that output register, so
// the next item is taken while it waits. Configuration writes are accepted at
// any time but belong between items.
module affinity_chunk_scheduler_unit import acs_pkg::*; #(
  parameter int MAX_THREADS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request beats
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [3:0] requester, [7:4] zero
  input  logic [0:0]          s_axis_tuser_i,  // [0] func
  // Result beats
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o,  // [15:0] chunk_start, [31:16] chunk_end
  output logic [2:0]          m_axis_tuser_o,  // [2:0] outcome
  // Configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t           cmd;
  sts_t           sts;
  logic [PosW-1:0] chunk_start;
  logic [PosW-1:0] chunk_end;

  assign cfg_ready_o = 1'b1;

  acs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acs_dp #(
    .MAX_THREADS(MAX_THREADS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .func_i        (s_axis_tuser_i[0]),
    .req_i         (s_axis_tdata_i[ReqW-1:0]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .chunk_start_o (chunk_start),
    .chunk_end_o   (chunk_end),
    .outcome_o     (m_axis_tuser_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

  assign m_axis_tdata_o = {chunk_end, chunk_start};

endmodule

@@ bench/affinity_chunk_scheduler_unit_tb.sv @@
// Self-checking regression bench for the affinity chunk scheduler unit.
`timescale 1ns / 100ps

module affinity_chunk_scheduler_unit_tb;
  import acs_pkg::*;

  localparam int MaxThreads    = 16;
  localparam int CountBits     = 16;
  localparam int RandomItems   = 700;
  localparam int HoldCycles    = 400;
  localparam int DrainCycles   = 60;
  localparam int WatchdogLimit = 4000;

  localparam logic FUNC_REQUEST = ~FUNC_BEGIN;

  typedef struct {
    logic [PosW-1:0] lo;
    logic [PosW-1:0] hi;
    outcome_e        outcome;
  } grant_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;   // [3:0] requester, [7:4] zero
  logic [0:0]          s_axis_tuser_i = '0;   // [0] func
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [31:0]         m_axis_tdata_o;        // [15:0] chunk_start, [31:16] chunk_end
  logic [2:0]          m_axis_tuser_o;        // [2:0] outcome
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Scheduler mirror: registers and per-worker range table
  logic [CountBits-1:0] iter_count_q   = ITER_COUNT_RESET;
  logic [TcW-1:0]       thread_count_q = THREAD_COUNT_RESET;
  logic [PosW-1:0]      tbl_next [MaxThreads];
  logic [PosW-1:0]      tbl_end  [MaxThreads];

  grant_t pending_grants[$];
  grant_t grant_head;
  int     mismatches  = 0;
  int     quiet_cycles = 0;
  logic   calm    = 1'b0;
  logic   holding = 1'b0;
  event   hold_ev;

  affinity_chunk_scheduler_unit #(
    .MAX_THREADS(MaxThreads),
    .COUNT_BITS (CountBits)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    for (int i = 0; i < MaxThreads; i++) begin
      tbl_next[i] = '0;
      tbl_end[i]  = '0;
    end
  end

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Zero and above-bound thread counts fold into 1..MaxThreads
  function automatic int unsigned eff_threads();
    int unsigned t;
    t = 32'(thread_count_q);
    if (t == 0) t = 1;
    if (t > MaxThreads) t = MaxThreads;
    return t;
  endfunction

  function automatic int unsigned span_left(input int unsigned w);
    if (tbl_end[w] > tbl_next[w]) return 32'(tbl_end[w]) - 32'(tbl_next[w]);
    return 0;
  endfunction

  // Work out the grant for one beat and advance the range table
  function automatic grant_t predict_grant(input logic func, input logic [ReqW-1:0] req);
    grant_t      g;
    int unsigned t, cnt, size, a, b, best, pick, chunk, i;
    bit          found;
    g.lo = '0;
    g.hi = '0;
    g.outcome = OC_STARTED;
    t = eff_threads();
    if (func == FUNC_BEGIN) begin
      // Split the count into equal slices, both ends clamped to the count
      cnt  = 32'(iter_count_q);
      size = (cnt + t - 1) / t;
      for (i = 0; i < MaxThreads; i++) begin
        a = i * size;
        b = (i + 1) * size;
        if (i < t) begin
          tbl_next[i] = PosW'((a > cnt) ? cnt : a);
          tbl_end[i]  = PosW'((b > cnt) ? cnt : b);
        end else begin
          tbl_next[i] = '0;
          tbl_end[i]  = '0;
        end
      end
    end else if (32'(req) >= t) begin
      g.outcome = OC_BAD_REQ;
    end else begin
      pick = 32'(req);
      found = 1'b1;
      g.outcome = OC_OWN;
      // Own range empty: steal from the fullest, lowest index on ties
      if (span_left(32'(req)) == 0) begin
        found = 1'b0;
        best = 0;
        g.outcome = OC_STOLEN;
        for (i = 0; i < t; i++) begin
          if (span_left(i) > best) begin
            best  = span_left(i);
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        g.outcome = OC_ALL_DONE;
      end else begin
        chunk = (span_left(pick) + t - 1) / t;
        g.lo = tbl_next[pick];
        g.hi = PosW'(32'(tbl_next[pick]) + chunk);
        tbl_next[pick] = g.hi;
      end
    end
    return g;
  endfunction

  // Offer one beat, optionally after a random gap, and log its grant on acceptance
  task automatic send_item(input logic func, input logic [ReqW-1:0] req);
    int gap;
    gap = 0;
    cfg_valid_i <= 1'b0;
    if (!calm && $urandom_range(99) < 35) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= {4'b0, req};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_grants.push_back(predict_grant(func, req));
  endtask

  // Drop both request channels and wait for every grant to come back
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    do @(posedge clk_i); while (pending_grants.size() != 0);
  endtask

  // Write one register; valid stays up so back-to-back writes need no gap
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_ITER_COUNT) iter_count_q = data;
    else if (idx == REG_THREAD_COUNT) thread_count_q = data[TcW-1:0];
  endtask

  function automatic logic [CfgDataW-1:0] pick_threads();
    logic [CfgDataW-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = CfgDataW'($urandom_range(17, 31));
      2:       v = CfgDataW'(MaxThreads);
      3:       v = CfgDataW'(1);
      default: v = CfgDataW'($urandom_range(1, MaxThreads));
    endcase
    // Junk in the unused upper bits now and then
    if ($urandom_range(3) == 0) v[CfgDataW-1:TcW] = (CfgDataW-TcW)'($urandom);
    return v;
  endfunction

  // Requests before any begin, bad requester, then a begin at reset settings
  task automatic test_reset_state();
    send_item(FUNC_REQUEST, 4'd0);
    send_item(FUNC_REQUEST, 4'd15);
    send_item(FUNC_BEGIN, 4'd0);
    send_item(FUNC_REQUEST, 4'd3);
  endtask

  // Count and thread count at their extremes, folded thread counts
  task automatic test_field_extremes();
    settle();
    write_reg(REG_ITER_COUNT, 16'd0);
    write_reg(REG_THREAD_COUNT, 16'd16);
    send_item(FUNC_BEGIN, 4'd9);
    send_item(FUNC_REQUEST, 4'd15);
    settle();
    write_reg(REG_ITER_COUNT, 16'hFFFF);
    send_item(FUNC_BEGIN, 4'd0);
    send_item(FUNC_REQUEST, 4'd15);
    send_item(FUNC_REQUEST, 4'd0);
    settle();
    write_reg(REG_THREAD_COUNT, 16'd1);
    send_item(FUNC_BEGIN, 4'd0);
    send_item(FUNC_REQUEST, 4'd0);
    send_item(FUNC_REQUEST, 4'd1);
    settle();
    write_reg(REG_THREAD_COUNT, 16'd0);
    send_item(FUNC_BEGIN, 4'd0);
    send_item(FUNC_REQUEST, 4'd0);
    send_item(FUNC_REQUEST, 4'd0);
    settle();
    write_reg(REG_THREAD_COUNT, 16'd31);
    send_item(FUNC_BEGIN, 4'd0);
    send_item(FUNC_REQUEST, 4'd15);
  endtask

  // Drain a worker so it steals, then change the thread count after begin
  task automatic test_steal_and_retarget();
    settle();
    write_reg(REG_ITER_COUNT, 16'd10);
    write_reg(REG_THREAD_COUNT, 16'd4);
    send_item(FUNC_BEGIN, 4'd0);
    send_item(FUNC_REQUEST, 4'd3);
    send_item(FUNC_REQUEST, 4'd3);
    settle();
    write_reg(REG_THREAD_COUNT, 16'd2);
    send_item(FUNC_REQUEST, 4'd0);
    send_item(FUNC_REQUEST, 4'd3);
    settle();
    write_reg(REG_THREAD_COUNT, 16'd8);
    send_item(FUNC_REQUEST, 4'd7);
  endtask

  // Hold the result side off long enough for the input to stall
  task automatic test_input_backpressure();
    settle();
    write_reg(REG_ITER_COUNT, 16'd500);
    write_reg(REG_THREAD_COUNT, 16'd8);
    send_item(FUNC_BEGIN, 4'd0);
    -> hold_ev;
    repeat (30) send_item(FUNC_REQUEST, 4'($urandom_range(7)));
  endtask

  // Random loops: mostly begin followed by valid requests, some noise
  task automatic test_random_phases();
    int sent, n, j, k, roll;
    sent = 0;
    k = 0;
    while (sent < RandomItems) begin
      settle();
      calm <= (k == 2);
      case ($urandom_range(9))
        0:       write_reg(REG_ITER_COUNT, 16'd0);
        1:       write_reg(REG_ITER_COUNT, 16'hFFFF);
        7, 8:    write_reg(REG_ITER_COUNT, 16'($urandom));
        9:       write_reg(REG_ITER_COUNT, 16'($urandom_range(1, 2000)));
        default: write_reg(REG_ITER_COUNT, 16'($urandom_range(1, 200)));
      endcase
      write_reg(REG_THREAD_COUNT, pick_threads());
      send_item(FUNC_BEGIN, 4'($urandom));
      sent++;
      n = $urandom_range(10, 60);
      for (j = 0; j < n; j++) begin
        // Change the thread count in the middle of some loops
        if (j == n / 2 && $urandom_range(3) == 0) begin
          settle();
          write_reg(REG_THREAD_COUNT, pick_threads());
        end
        roll = $urandom_range(99);
        if (roll < 85) send_item(FUNC_REQUEST, 4'($urandom_range(eff_threads() - 1)));
        else if (roll < 96) send_item(FUNC_REQUEST, 4'($urandom));
        else send_item(FUNC_BEGIN, 4'($urandom));
        sent++;
      end
      k++;
    end
    calm <= 1'b0;
  endtask

  // Result side: random stalls, none while calm, held low during a hold-off
  always @(posedge clk_i) begin
    if (holding) m_axis_tready_i <= 1'b0;
    else if (calm) m_axis_tready_i <= 1'b1;
    else m_axis_tready_i <= ($urandom_range(99) >= 35);
  end

  initial begin
    forever begin
      @(hold_ev);
      holding <= 1'b1;
      repeat (HoldCycles) @(posedge clk_i);
      holding <= 1'b0;
    end
  end

  // Match each result beat against the oldest logged grant
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result beat: chunk_start %0d chunk_end %0d outcome %0d",
               m_axis_tdata_o[15:0], m_axis_tdata_o[31:16], m_axis_tuser_o);
        mismatches++;
      end else begin
        grant_head = pending_grants.pop_front();
        if (m_axis_tdata_o[15:0] !== grant_head.lo) begin
          $error("chunk_start: expected %0d, got %0d", grant_head.lo, m_axis_tdata_o[15:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[31:16] !== grant_head.hi) begin
          $error("chunk_end: expected %0d, got %0d", grant_head.hi, m_axis_tdata_o[31:16]);
          mismatches++;
        end
        if (m_axis_tuser_o !== grant_head.outcome) begin
          $error("outcome: expected %0d, got %0d", grant_head.outcome, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  // End the run when no channel moves a beat for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("affinity_chunk_scheduler_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_field_extremes();
    test_steal_and_retarget();
    test_input_backpressure();
    test_random_phases();
    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("affinity_chunk_scheduler_unit regression: pass");
    end else begin
      $display("affinity_chunk_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule
